// ===== rtl/core/mseu_pkg.sv =====
// Package for the MIPS subset execute unit: decoded request format,
// opcode and function codes, status codes and reset constants.
// No dependencies.
package mseu_pkg;

	// Primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LB      = 6'd32;
	localparam logic [5:0] OP_LH      = 6'd33;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_LBU     = 6'd36;
	localparam logic [5:0] OP_LHU     = 6'd37;
	localparam logic [5:0] OP_SB      = 6'd40;
	localparam logic [5:0] OP_SH      = 6'd41;
	localparam logic [5:0] OP_SW      = 6'd43;

	// SPECIAL function codes
	localparam logic [5:0] FN_SLL  = 6'd0;
	localparam logic [5:0] FN_SRL  = 6'd2;
	localparam logic [5:0] FN_SRA  = 6'd3;
	localparam logic [5:0] FN_SLLV = 6'd4;
	localparam logic [5:0] FN_ADDU = 6'd33;

	// REGIMM rt codes
	localparam logic [4:0] RI_BLTZ   = 5'd0;
	localparam logic [4:0] RI_BGEZ   = 5'd1;
	localparam logic [4:0] RI_BLTZAL = 5'd16;
	localparam logic [4:0] RI_BGEZAL = 5'd17;

	localparam logic [4:0] LINK_REG = 5'd31;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_OP = 2'd1;
	localparam logic [1:0] ST_BAD_FN = 2'd2;
	localparam logic [1:0] ST_BAD_RI = 2'd3;

	localparam logic [31:0] START_RESET = 32'h0040_0000;

	typedef enum logic [4:0] {
		K_SLL, K_SRL, K_SRA, K_SLLV, K_ADDU,
		K_BLTZ, K_BGEZ, K_BLTZAL, K_BGEZAL,
		K_J, K_JAL, K_BEQ, K_BNE, K_BLEZ, K_BGTZ,
		K_ADDI, K_SLTI, K_SLTIU, K_ANDI, K_ORI, K_XORI, K_LUI,
		K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW,
		K_BAD
	} kind_t;

	// Classified instruction as it travels from front to back
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  dest;
		logic        wen;
		logic [4:0]  sa;
		logic [25:0] target;
	} dec_t;

endpackage

// ===== rtl/core/mseu_ifs.sv =====
// Valid/ready channel interfaces of the MIPS subset execute unit.
// No dependencies.
interface mseu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

interface mseu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic        reg_write_valid;
	logic [4:0]  reg_write_index;
	logic [31:0] reg_write_value;
	logic [1:0]  status;
	modport source (output valid, output next_pc, output reg_write_valid,
		output reg_write_index, output reg_write_value, output status, input ready);
	modport sink (input valid, input next_pc, input reg_write_valid,
		input reg_write_index, input reg_write_value, input status, output ready);
endinterface

// ===== rtl/core/mseu_front.sv =====
// Front end: accepts instruction requests and classifies them.
// Depends on mseu_pkg and mseu_in_if.
module mseu_front (
	mseu_in_if.sink          instr_ch,
	input  logic             blocked,
	input  logic             q_full,
	output logic             push,
	output mseu_pkg::dec_t   push_data
);

	logic [31:0]     ins;
	logic [5:0]      op;
	logic [5:0]      fn;
	logic [4:0]      rt;
	logic [4:0]      rd;
	mseu_pkg::kind_t kind;
	logic [1:0]      status;
	logic [4:0]      dest;
	logic            wr;

	assign instr_ch.ready = !q_full && !blocked;
	assign push = instr_ch.valid && instr_ch.ready;

	assign ins = instr_ch.instruction;
	assign op  = ins[31:26];
	assign fn  = ins[5:0];
	assign rt  = ins[20:16];
	assign rd  = ins[15:11];

	// Classify opcode, function and regimm codes
	always_comb begin
		kind   = mseu_pkg::K_BAD;
		status = mseu_pkg::ST_OK;
		dest   = 5'd0;
		wr     = 1'b0;
		case (op)
			mseu_pkg::OP_SPECIAL: begin
				dest = rd;
				wr   = 1'b1;
				case (fn)
					mseu_pkg::FN_SLL:  kind = mseu_pkg::K_SLL;
					mseu_pkg::FN_SRL:  kind = mseu_pkg::K_SRL;
					mseu_pkg::FN_SRA:  kind = mseu_pkg::K_SRA;
					mseu_pkg::FN_SLLV: kind = mseu_pkg::K_SLLV;
					mseu_pkg::FN_ADDU: kind = mseu_pkg::K_ADDU;
					default: begin
						status = mseu_pkg::ST_BAD_FN;
						wr     = 1'b0;
					end
				endcase
			end
			mseu_pkg::OP_REGIMM: begin
				case (rt)
					mseu_pkg::RI_BLTZ: kind = mseu_pkg::K_BLTZ;
					mseu_pkg::RI_BGEZ: kind = mseu_pkg::K_BGEZ;
					mseu_pkg::RI_BLTZAL: begin
						kind = mseu_pkg::K_BLTZAL;
						dest = mseu_pkg::LINK_REG;
						wr   = 1'b1;
					end
					mseu_pkg::RI_BGEZAL: begin
						kind = mseu_pkg::K_BGEZAL;
						dest = mseu_pkg::LINK_REG;
						wr   = 1'b1;
					end
					default: status = mseu_pkg::ST_BAD_RI;
				endcase
			end
			mseu_pkg::OP_J:    kind = mseu_pkg::K_J;
			mseu_pkg::OP_JAL: begin
				kind = mseu_pkg::K_JAL;
				dest = mseu_pkg::LINK_REG;
				wr   = 1'b1;
			end
			mseu_pkg::OP_BEQ:  kind = mseu_pkg::K_BEQ;
			mseu_pkg::OP_BNE:  kind = mseu_pkg::K_BNE;
			mseu_pkg::OP_BLEZ: kind = mseu_pkg::K_BLEZ;
			mseu_pkg::OP_BGTZ: kind = mseu_pkg::K_BGTZ;
			mseu_pkg::OP_ADDI, mseu_pkg::OP_ADDIU: begin
				kind = mseu_pkg::K_ADDI; dest = rt; wr = 1'b1;
			end
			mseu_pkg::OP_SLTI:  begin kind = mseu_pkg::K_SLTI;  dest = rt; wr = 1'b1; end
			mseu_pkg::OP_SLTIU: begin kind = mseu_pkg::K_SLTIU; dest = rt; wr = 1'b1; end
			mseu_pkg::OP_ANDI:  begin kind = mseu_pkg::K_ANDI;  dest = rt; wr = 1'b1; end
			mseu_pkg::OP_ORI:   begin kind = mseu_pkg::K_ORI;   dest = rt; wr = 1'b1; end
			mseu_pkg::OP_XORI:  begin kind = mseu_pkg::K_XORI;  dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LUI:   begin kind = mseu_pkg::K_LUI;   dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LB:    begin kind = mseu_pkg::K_LB;    dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LH:    begin kind = mseu_pkg::K_LH;    dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LW:    begin kind = mseu_pkg::K_LW;    dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LBU:   begin kind = mseu_pkg::K_LBU;   dest = rt; wr = 1'b1; end
			mseu_pkg::OP_LHU:   begin kind = mseu_pkg::K_LHU;   dest = rt; wr = 1'b1; end
			mseu_pkg::OP_SB:    kind = mseu_pkg::K_SB;
			mseu_pkg::OP_SH:    kind = mseu_pkg::K_SH;
			mseu_pkg::OP_SW:    kind = mseu_pkg::K_SW;
			default: status = mseu_pkg::ST_BAD_OP;
		endcase
	end

	// Pack the request; writes to register zero are dropped here
	always_comb begin
		push_data        = '0;
		push_data.kind   = kind;
		push_data.status = status;
		push_data.rs     = ins[25:21];
		push_data.rt     = rt;
		push_data.dest   = (wr && (dest != 5'd0)) ? dest : 5'd0;
		push_data.wen    = wr && (dest != 5'd0);
		push_data.sa     = ins[10:6];
		push_data.target = ins[25:0];
	end

endmodule

// ===== rtl/core/mseu_queue.sv =====
// Two-entry queue between the classifying front end and the execute back end.
// Depends on mseu_pkg.
module mseu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mseu_pkg::dec_t push_data,
	input  logic           pop,
	output logic           head_valid,
	output mseu_pkg::dec_t head_data,
	output logic           full
);

	mseu_pkg::dec_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head_data  = entry_q[rd_ptr_q];

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop && head_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/mseu_back.sv =====
// Execute back end: register file read, execute with memory access, load
// return and result register. Holds PC, register file and data memory.
// Depends on mseu_pkg and mseu_out_if.
module mseu_back #(
	parameter int DATA_MEMORY_BYTES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  mseu_pkg::dec_t  head_data,
	output logic            pop,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output logic            clr_busy,
	mseu_out_if.source      result_ch
);

	localparam int AW   = $clog2(DATA_MEMORY_BYTES);
	localparam int LW   = AW - 2;
	localparam int ROWS = DATA_MEMORY_BYTES / 4;

	logic adv;

	// Storage
	logic [31:0] rf_q [32];
	logic [31:0] rf_vld_q;
	logic [7:0]  mem_q [4][ROWS];
	logic [31:0] pc_q;
	logic        clr_busy_q;
	logic [LW-1:0] clr_row_q;

	// Stage 2: operands read
	logic           v_s2;
	mseu_pkg::dec_t d_s2;
	logic [31:0]    a_raw_s2;
	logic [31:0]    b_raw_s2;

	// Stage 3: memory return
	logic           v_s3;
	mseu_pkg::kind_t kind_s3;
	logic           wen_s3;
	logic [4:0]     dest_s3;
	logic [31:0]    alu_s3;
	logic [31:0]    npc_s3;
	logic [1:0]     status_s3;
	logic [1:0]     off_s3;
	logic [7:0]     rd_s3 [4];

	// Result register
	logic           out_v_q;
	logic [31:0]    out_npc_q;
	logic           out_wv_q;
	logic [4:0]     out_wi_q;
	logic [31:0]    out_wval_q;
	logic [1:0]     out_st_q;

	// Execute signals
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] seq;
	logic [31:0] simm;
	logic [31:0] imm;
	logic [31:0] btarget;
	logic [31:0] ea;
	logic [31:0] npc;
	logic [31:0] alu;
	logic        neg;
	logic        zero;
	logic [2:0]  st_nb;
	logic [31:0] res_s3;
	logic [31:0] ld_word;
	logic        fwd_a;
	logic        fwd_b;

	// Lane addressing
	logic [1:0]    lane_idx [4];
	logic [AW-1:0] lane_addr [4];
	logic [LW-1:0] lane_row [4];
	logic [7:0]    lane_wd [4];
	logic [3:0]    lane_we;

	// Whole back end moves when the result register is free or taken
	assign adv      = !out_v_q || result_ch.ready;
	assign pop      = adv && head_valid;
	assign clr_busy = clr_busy_q;

	// Forward the instruction in stage 3 into stage 2 operands
	assign fwd_a = v_s3 && wen_s3 && (dest_s3 == d_s2.rs);
	assign fwd_b = v_s3 && wen_s3 && (dest_s3 == d_s2.rt);
	assign a     = fwd_a ? res_s3 : a_raw_s2;
	assign b     = fwd_b ? res_s3 : b_raw_s2;

	// Execute: ALU, branch resolution and effective address
	always_comb begin
		imm     = {16'd0, d_s2.target[15:0]};
		simm    = {{16{d_s2.target[15]}}, d_s2.target[15:0]};
		seq     = pc_q + 32'd4;
		btarget = seq + {simm[29:0], 2'b00};
		ea      = a + simm;
		neg     = a[31];
		zero    = (a == 32'd0);
		npc     = seq;
		alu     = 32'd0;
		st_nb   = 3'd0;
		case (d_s2.kind)
			mseu_pkg::K_SLL:  alu = b << d_s2.sa;
			mseu_pkg::K_SRL:  alu = b >> d_s2.sa;
			mseu_pkg::K_SRA:  alu = 32'($signed(b) >>> d_s2.sa);
			mseu_pkg::K_SLLV: alu = b << a[4:0];
			mseu_pkg::K_ADDU: alu = a + b;
			mseu_pkg::K_BLTZ: if (neg) npc = btarget;
			mseu_pkg::K_BGEZ: if (!neg) npc = btarget;
			mseu_pkg::K_BLTZAL: begin
				alu = seq;
				if (neg) npc = btarget;
			end
			mseu_pkg::K_BGEZAL: begin
				alu = seq;
				if (!neg) npc = btarget;
			end
			mseu_pkg::K_J:    npc = {seq[31:28], d_s2.target, 2'b00};
			mseu_pkg::K_JAL: begin
				npc = {seq[31:28], d_s2.target, 2'b00};
				alu = seq;
			end
			mseu_pkg::K_BEQ:  if (a == b) npc = btarget;
			mseu_pkg::K_BNE:  if (a != b) npc = btarget;
			mseu_pkg::K_BLEZ: if (neg || zero) npc = btarget;
			mseu_pkg::K_BGTZ: if (!neg && !zero) npc = btarget;
			mseu_pkg::K_ADDI: alu = a + simm;
			mseu_pkg::K_SLTI: alu = {31'd0, $signed(a) < $signed(simm)};
			mseu_pkg::K_SLTIU: alu = {31'd0, a < simm};
			mseu_pkg::K_ANDI: alu = a & imm;
			mseu_pkg::K_ORI:  alu = a | imm;
			mseu_pkg::K_XORI: alu = a ^ imm;
			mseu_pkg::K_LUI:  alu = {d_s2.target[15:0], 16'd0};
			mseu_pkg::K_SB:   st_nb = 3'd1;
			mseu_pkg::K_SH:   st_nb = 3'd2;
			mseu_pkg::K_SW:   st_nb = 3'd4;
			default:          alu = 32'd0;
		endcase
		if (d_s2.status != mseu_pkg::ST_OK) begin
			npc   = pc_q;
			st_nb = 3'd0;
		end
	end

	// Map the four consecutive bytes onto the four lanes
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			lane_idx[l]  = 2'(l) - ea[1:0];
			lane_addr[l] = ea[AW-1:0] + AW'(lane_idx[l]);
			lane_row[l]  = lane_addr[l][AW-1:2];
			lane_wd[l]   = 8'(b >> {lane_idx[l], 3'b000});
			lane_we[l]   = adv && v_s2 && ({1'b0, lane_idx[l]} < st_nb);
		end
	end

	// Data memory: clear sweep after reset, stores, registered reads
	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			if (clr_busy_q) begin
				mem_q[l][clr_row_q] <= 8'd0;
			end else if (lane_we[l]) begin
				mem_q[l][lane_row[l]] <= lane_wd[l];
			end
			if (adv) begin
				rd_s3[l] <= mem_q[l][lane_row[l]];
			end
		end
	end

	// Clear sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + LW'(1);
			if (clr_row_q == LW'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Load return: reassemble bytes and extend
	always_comb begin
		ld_word = {rd_s3[2'(off_s3 + 2'd3)], rd_s3[2'(off_s3 + 2'd2)],
			rd_s3[2'(off_s3 + 2'd1)], rd_s3[off_s3]};
		case (kind_s3)
			mseu_pkg::K_LB:  res_s3 = {{24{ld_word[7]}}, ld_word[7:0]};
			mseu_pkg::K_LBU: res_s3 = {24'd0, ld_word[7:0]};
			mseu_pkg::K_LH:  res_s3 = {{16{ld_word[15]}}, ld_word[15:0]};
			mseu_pkg::K_LHU: res_s3 = {16'd0, ld_word[15:0]};
			mseu_pkg::K_LW:  res_s3 = ld_word;
			default:         res_s3 = alu_s3;
		endcase
	end

	// Register file: write from stage 3, registered read with write bypass
	always_ff @(posedge clk) begin
		if (adv && v_s3 && wen_s3) begin
			rf_q[dest_s3] <= res_s3;
		end
		if (adv) begin
			if (v_s3 && wen_s3 && (dest_s3 == head_data.rs)) begin
				a_raw_s2 <= res_s3;
			end else begin
				a_raw_s2 <= rf_vld_q[head_data.rs] ? rf_q[head_data.rs] : 32'd0;
			end
			if (v_s3 && wen_s3 && (dest_s3 == head_data.rt)) begin
				b_raw_s2 <= res_s3;
			end else begin
				b_raw_s2 <= rf_vld_q[head_data.rt] ? rf_q[head_data.rt] : 32'd0;
			end
		end
	end

	// Register valid bits: an unwritten register reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (adv && v_s3 && wen_s3) begin
			rf_vld_q[dest_s3] <= 1'b1;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2      <= head_data;
			kind_s3   <= d_s2.kind;
			wen_s3    <= d_s2.wen && (d_s2.status == mseu_pkg::ST_OK);
			dest_s3   <= d_s2.dest;
			alu_s3    <= alu;
			npc_s3    <= npc;
			status_s3 <= d_s2.status;
			off_s3    <= ea[1:0];
			out_npc_q <= npc_s3;
			out_wv_q  <= wen_s3;
			out_wi_q  <= wen_s3 ? dest_s3 : 5'd0;
			out_wval_q <= wen_s3 ? res_s3 : 32'd0;
			out_st_q  <= status_s3;
		end
	end

	// Pipeline valid bits and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			pc_q    <= mseu_pkg::START_RESET;
		end else begin
			if (adv) begin
				v_s2    <= head_valid;
				v_s3    <= v_s2;
				out_v_q <= v_s3;
			end
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (adv && v_s2) begin
				pc_q <= npc;
			end
		end
	end

	assign result_ch.valid           = out_v_q;
	assign result_ch.next_pc         = out_npc_q;
	assign result_ch.reg_write_valid = out_wv_q;
	assign result_ch.reg_write_index = out_wi_q;
	assign result_ch.reg_write_value = out_wval_q;
	assign result_ch.status          = out_st_q;

endmodule

// ===== rtl/core/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: front end, queue, back end.
// Depends on mseu_pkg, mseu_ifs, mseu_front, mseu_queue and mseu_back.
//
// Usage:
//   instr_ch carries one instruction word per request, fetched at the PC
//   that the previous result reported (or the start address). result_ch
//   returns one request per instruction: next PC, register write and status.
//   cfg_we/cfg_wdata load the start address, which also reloads the PC;
//   write it only while no instruction is in flight.
// Timing:
//   An accepted instruction passes from the queue into the operand registers,
//   through execute with memory read, and through load return into the
//   result register. One instruction per cycle is sustained while result_ch
//   is ready; operand forwarding from the load return stage keeps
//   dependent instructions back to back.
// Reset:
//   PC goes to 0x00400000, all registers read zero. The data memory is
//   then swept to zero one four-byte row a cycle; instr_ch.ready stays
//   low meanwhile. DATA_MEMORY_BYTES must be a power of two.
// Back-pressure:
//   When result_ch stalls, the back end holds; the two-entry queue keeps
//   accepting until full.
module mips_subset_execute_unit #(
	parameter int DATA_MEMORY_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mseu_in_if.sink     instr_ch,
	mseu_out_if.source  result_ch,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic           push;
	mseu_pkg::dec_t push_data;
	logic           pop;
	logic           head_valid;
	mseu_pkg::dec_t head_data;
	logic           q_full;
	logic           clr_busy;

	mseu_front u_front (
		.instr_ch  (instr_ch),
		.blocked   (clr_busy),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	mseu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.full       (q_full)
	);

	mseu_back #(
		.DATA_MEMORY_BYTES (DATA_MEMORY_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.clr_busy   (clr_busy),
		.result_ch  (result_ch)
	);

	// No request enters during the memory clear sweep
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !instr_ch.ready)
		else $error("instruction accepted during memory clear");

	// A faulting instruction never reports a register write
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && (result_ch.status != mseu_pkg::ST_OK))
		|-> !result_ch.reg_write_valid)
		else $error("register write reported with error status");

	// Register zero is never reported as written
	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.reg_write_valid)
		|-> (result_ch.reg_write_index != 5'd0))
		else $error("write to register zero reported");

endmodule
